FILE: hw/rtl/fwce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwce_pkg
// Shared types and codes for the four-way container engine.
// ----------------------------------------------------------------------------
package fwce_pkg;

    localparam int KEY_PORT_W = 64;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        SEL_STACK = 2'd0,
        SEL_FIFO  = 2'd1,
        SEL_MAXH  = 2'd2,
        SEL_MINH  = 2'd3
    } sel_e_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_POP_WAIT,
        BS_INS_WAIT
    } back_state_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_INS_CHK,
        HS_INS_CMP,
        HS_REM_TOP,
        HS_REM_LAST,
        HS_REM_CHK,
        HS_REM_C1,
        HS_REM_C2,
        HS_REM_CMP
    } heap_state_t;

    // classified command as it sits in the queue
    typedef struct packed {
        cmd_e_t                  cmd;
        sel_e_t                  src;
        sel_e_t                  dst;
        logic                    same;
        logic [KEY_PORT_W-1:0]   key;
    } cmd_t;

    // requests from the back end to one heap unit
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } heap_req_t;

endpackage

FILE: hw/rtl/fwce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwce_front
// Input side: classifies each command beat and hands it to the queue.
// ----------------------------------------------------------------------------
module fwce_front #(
    parameter int KEY_BITS = 64
) (
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic [1:0]                       source_sel,
    input  logic [1:0]                       target_sel,
    input  logic [fwce_pkg::KEY_PORT_W-1:0]  key_in,
    input  logic                             q_full,
    output logic                             q_push,
    output fwce_pkg::cmd_t                   q_data
);

    localparam logic [fwce_pkg::KEY_PORT_W-1:0] KEY_MASK =
        {fwce_pkg::KEY_PORT_W{1'b1}} >> (fwce_pkg::KEY_PORT_W - KEY_BITS);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.cmd  = fwce_pkg::cmd_e_t'(command);
        q_data.src  = fwce_pkg::sel_e_t'(source_sel);
        q_data.dst  = fwce_pkg::sel_e_t'(target_sel);
        // a move onto itself skips the full check
        q_data.same = (source_sel == target_sel);
        q_data.key  = key_in & KEY_MASK;
    end

endmodule

FILE: hw/rtl/fwce_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwce_cmd_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module fwce_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fwce_pkg::cmd_t  push_data,
    input  logic            pop,
    output logic            q_valid,
    output logic            q_full,
    output fwce_pkg::cmd_t  head,
    output logic [1:0]      level
);

    fwce_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     level_reg, level_next;

    assign q_valid = (level_reg != 2'd0);
    assign q_full  = (level_reg == 2'd2);
    assign head    = entry_reg[rd_ptr_reg];
    assign level   = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/fwce_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwce_heap
// Binary heap unit: one memory, sift up on insert, sift down on remove.
// ----------------------------------------------------------------------------
module fwce_heap #(
    parameter int   CAPACITY = 1024,
    parameter int   KEY_BITS = 64,
    parameter logic IS_MIN   = 1'b0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fwce_pkg::heap_req_t               req,
    input  logic [KEY_BITS-1:0]               ins_key,
    output logic [$clog2(CAPACITY+1)-1:0]     count,
    output logic [KEY_BITS-1:0]               top_key,
    output logic                              done
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = AW + 2;

    fwce_pkg::heap_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       cidx_reg, cidx_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] top_reg, top_next;
    logic [KEY_BITS-1:0] child_reg, child_next;
    logic                done_reg, done_next;

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rdata_reg;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [AW-1:0]       raddr;

    logic [AW-1:0]       parent;
    logic [CW-1:0]       c_wide, c1_wide, n_wide;
    logic                c_lt_n, c1_lt_n;

    function automatic logic above(input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        return IS_MIN ? (a < b) : (a > b);
    endfunction

    assign count   = cnt_reg;
    assign top_key = top_reg;
    assign done    = done_reg;

    always_comb
    begin
        parent  = (idx_reg - AW'(1)) >> 1;
        c_wide  = {1'b0, idx_reg, 1'b1};
        c1_wide = c_wide + CW'(1);
        n_wide  = CW'(cnt_reg);
        c_lt_n  = (c_wide < n_wide);
        c1_lt_n = (c1_wide < n_wide);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cidx_next  = cidx_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        child_next = child_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = key_reg;
        raddr      = '0;
        case (state_reg)
            fwce_pkg::HS_IDLE:
            begin
                if (req.clr)
                begin
                    cnt_next = '0;
                end
                else if (req.ins)
                begin
                    idx_next   = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    key_next   = ins_key;
                    state_next = fwce_pkg::HS_INS_CHK;
                end
                else if (req.rem)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    raddr      = '0;
                    state_next = fwce_pkg::HS_REM_TOP;
                end
            end
            fwce_pkg::HS_INS_CHK:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = fwce_pkg::HS_IDLE;
                end
                else
                begin
                    raddr      = parent;
                    state_next = fwce_pkg::HS_INS_CMP;
                end
            end
            fwce_pkg::HS_INS_CMP:
            begin
                we = 1'b1;
                if (above(key_reg, rdata_reg))
                begin
                    wdata      = rdata_reg;
                    idx_next   = parent;
                    state_next = fwce_pkg::HS_INS_CHK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = fwce_pkg::HS_IDLE;
                end
            end
            fwce_pkg::HS_REM_TOP:
            begin
                top_next   = rdata_reg;
                raddr      = cnt_reg[AW-1:0];
                state_next = fwce_pkg::HS_REM_LAST;
            end
            fwce_pkg::HS_REM_LAST:
            begin
                key_next   = rdata_reg;
                idx_next   = '0;
                state_next = fwce_pkg::HS_REM_CHK;
            end
            fwce_pkg::HS_REM_CHK:
            begin
                if (!c_lt_n)
                begin
                    we         = (cnt_reg != '0);
                    done_next  = 1'b1;
                    state_next = fwce_pkg::HS_IDLE;
                end
                else
                begin
                    raddr      = c_wide[AW-1:0];
                    state_next = fwce_pkg::HS_REM_C1;
                end
            end
            fwce_pkg::HS_REM_C1:
            begin
                child_next = rdata_reg;
                cidx_next  = c_wide[AW-1:0];
                if (c1_lt_n)
                begin
                    raddr      = c1_wide[AW-1:0];
                    state_next = fwce_pkg::HS_REM_C2;
                end
                else
                begin
                    state_next = fwce_pkg::HS_REM_CMP;
                end
            end
            fwce_pkg::HS_REM_C2:
            begin
                if (above(rdata_reg, child_reg))
                begin
                    child_next = rdata_reg;
                    cidx_next  = c1_wide[AW-1:0];
                end
                state_next = fwce_pkg::HS_REM_CMP;
            end
            fwce_pkg::HS_REM_CMP:
            begin
                we = 1'b1;
                if (above(child_reg, key_reg))
                begin
                    wdata      = child_reg;
                    idx_next   = cidx_reg;
                    state_next = fwce_pkg::HS_REM_CHK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = fwce_pkg::HS_IDLE;
                end
            end
            default:
            begin
                state_next = fwce_pkg::HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwce_pkg::HS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cidx_reg  <= cidx_next;
        key_reg   <= key_next;
        top_reg   <= top_next;
        child_reg <= child_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

FILE: hw/rtl/fwce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwce_back
// Execution side: stack and queue stores, two heap units, result register.
// ----------------------------------------------------------------------------
module fwce_back #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  fwce_pkg::cmd_t                   q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fwce_pkg::KEY_PORT_W-1:0]  key_out,
    output logic                             was_empty
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_CW = (CNT_W + 1)'(CAPACITY);

    fwce_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]    stack_cnt_reg, stack_cnt_next;
    logic [CNT_W-1:0]    fifo_cnt_reg, fifo_cnt_next;
    logic [AW-1:0]       fifo_head_reg, fifo_head_next;
    fwce_pkg::sel_e_t    src_reg, src_next;
    fwce_pkg::sel_e_t    dst_reg, dst_next;
    logic                move_reg, move_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0] key_out_reg, key_out_next;
    logic                was_empty_reg, was_empty_next;

    logic [KEY_BITS-1:0] stack_mem [CAPACITY];
    logic [KEY_BITS-1:0] fifo_mem [CAPACITY];
    logic [KEY_BITS-1:0] stack_rdata_reg, fifo_rdata_reg;
    logic                stack_we, fifo_we;
    logic [AW-1:0]       stack_waddr, fifo_waddr, stack_raddr;
    logic [CNT_W:0]      fifo_sum;

    fwce_pkg::heap_req_t maxh_req, minh_req;
    logic [CNT_W-1:0]    maxh_cnt, minh_cnt;
    logic [KEY_BITS-1:0] maxh_top, minh_top;
    logic                maxh_done, minh_done;

    logic                push_en, pop_en, clr_en;
    fwce_pkg::sel_e_t    push_sel, pop_sel;
    logic [KEY_BITS-1:0] push_key, pop_val;
    logic                pop_ready;
    logic [CNT_W-1:0]    src_cnt, dst_cnt;

    function automatic logic [CNT_W-1:0] cnt_of(input fwce_pkg::sel_e_t sel,
                                                input logic [CNT_W-1:0] s_c,
                                                input logic [CNT_W-1:0] f_c,
                                                input logic [CNT_W-1:0] x_c,
                                                input logic [CNT_W-1:0] n_c);
        logic [CNT_W-1:0] r;
        case (sel)
            fwce_pkg::SEL_STACK: r = s_c;
            fwce_pkg::SEL_FIFO:  r = f_c;
            fwce_pkg::SEL_MAXH:  r = x_c;
            default:             r = n_c;
        endcase
        return r;
    endfunction

    fwce_heap #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .IS_MIN   (1'b0)
    ) u_maxh (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (maxh_req),
        .ins_key (push_key),
        .count   (maxh_cnt),
        .top_key (maxh_top),
        .done    (maxh_done)
    );

    fwce_heap #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .IS_MIN   (1'b1)
    ) u_minh (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (minh_req),
        .ins_key (push_key),
        .count   (minh_cnt),
        .top_key (minh_top),
        .done    (minh_done)
    );

    assign out_valid = out_valid_reg;
    assign key_out   = fwce_pkg::KEY_PORT_W'(key_out_reg);
    assign was_empty = was_empty_reg;

    always_comb
    begin
        src_cnt     = cnt_of(q_head.src, stack_cnt_reg, fifo_cnt_reg, maxh_cnt, minh_cnt);
        dst_cnt     = cnt_of(q_head.dst, stack_cnt_reg, fifo_cnt_reg, maxh_cnt, minh_cnt);
        stack_raddr = AW'(stack_cnt_reg - CNT_W'(1));
        fifo_sum    = (CNT_W + 1)'(fifo_head_reg) + (CNT_W + 1)'(fifo_cnt_reg);
        if (fifo_sum >= CAP_CW)
        begin
            fifo_sum = fifo_sum - CAP_CW;
        end
        case (src_reg)
            fwce_pkg::SEL_STACK:
            begin
                pop_val   = stack_rdata_reg;
                pop_ready = 1'b1;
            end
            fwce_pkg::SEL_FIFO:
            begin
                pop_val   = fifo_rdata_reg;
                pop_ready = 1'b1;
            end
            fwce_pkg::SEL_MAXH:
            begin
                pop_val   = maxh_top;
                pop_ready = maxh_done;
            end
            default:
            begin
                pop_val   = minh_top;
                pop_ready = minh_done;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        move_next      = move_reg;
        key_out_next   = key_out_reg;
        was_empty_next = was_empty_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        push_en        = 1'b0;
        push_sel       = q_head.src;
        push_key       = q_head.key[KEY_BITS-1:0];
        pop_en         = 1'b0;
        pop_sel        = q_head.src;
        clr_en         = 1'b0;

        case (state_reg)
            fwce_pkg::BS_IDLE:
            begin
                if (q_valid && !(q_head.cmd == fwce_pkg::CMD_POP && out_valid_reg))
                begin
                    q_pop    = 1'b1;
                    src_next = q_head.src;
                    dst_next = q_head.dst;
                    case (q_head.cmd)
                        fwce_pkg::CMD_PUSH:
                        begin
                            push_en = (src_cnt != CAP_C);
                        end
                        fwce_pkg::CMD_MOVE:
                        begin
                            if (src_cnt != '0 && (q_head.same || dst_cnt != CAP_C))
                            begin
                                pop_en     = 1'b1;
                                move_next  = 1'b1;
                                state_next = fwce_pkg::BS_POP_WAIT;
                            end
                        end
                        fwce_pkg::CMD_POP:
                        begin
                            if (src_cnt == '0)
                            begin
                                out_valid_next = 1'b1;
                                key_out_next   = '0;
                                was_empty_next = 1'b1;
                            end
                            else
                            begin
                                pop_en     = 1'b1;
                                move_next  = 1'b0;
                                state_next = fwce_pkg::BS_POP_WAIT;
                            end
                        end
                        default:
                        begin
                            clr_en = 1'b1;
                        end
                    endcase
                end
            end
            fwce_pkg::BS_POP_WAIT:
            begin
                if (pop_ready)
                begin
                    if (move_reg)
                    begin
                        push_en  = 1'b1;
                        push_sel = dst_reg;
                        push_key = pop_val;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        key_out_next   = pop_val;
                        was_empty_next = 1'b0;
                        state_next     = fwce_pkg::BS_IDLE;
                    end
                end
            end
            fwce_pkg::BS_INS_WAIT:
            begin
                if (maxh_done || minh_done)
                begin
                    state_next = fwce_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = fwce_pkg::BS_IDLE;
            end
        endcase

        // push side effects
        if (push_en)
        begin
            if (push_sel == fwce_pkg::SEL_MAXH || push_sel == fwce_pkg::SEL_MINH)
            begin
                state_next = fwce_pkg::BS_INS_WAIT;
            end
            else
            begin
                state_next = fwce_pkg::BS_IDLE;
            end
        end
    end

    always_comb
    begin
        stack_cnt_next = stack_cnt_reg;
        fifo_cnt_next  = fifo_cnt_reg;
        fifo_head_next = fifo_head_reg;
        stack_we       = push_en && push_sel == fwce_pkg::SEL_STACK;
        fifo_we        = push_en && push_sel == fwce_pkg::SEL_FIFO;
        stack_waddr    = stack_cnt_reg[AW-1:0];
        fifo_waddr     = fifo_sum[AW-1:0];
        maxh_req.ins   = push_en && push_sel == fwce_pkg::SEL_MAXH;
        minh_req.ins   = push_en && push_sel == fwce_pkg::SEL_MINH;
        maxh_req.rem   = pop_en && pop_sel == fwce_pkg::SEL_MAXH;
        minh_req.rem   = pop_en && pop_sel == fwce_pkg::SEL_MINH;
        maxh_req.clr   = clr_en;
        minh_req.clr   = clr_en;

        if (clr_en)
        begin
            stack_cnt_next = '0;
            fifo_cnt_next  = '0;
            fifo_head_next = '0;
        end
        if (stack_we)
        begin
            stack_cnt_next = stack_cnt_reg + CNT_W'(1);
        end
        if (fifo_we)
        begin
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        end
        if (pop_en && pop_sel == fwce_pkg::SEL_STACK)
        begin
            stack_cnt_next = stack_cnt_reg - CNT_W'(1);
        end
        if (pop_en && pop_sel == fwce_pkg::SEL_FIFO)
        begin
            fifo_cnt_next  = fifo_cnt_reg - CNT_W'(1);
            fifo_head_next = (CNT_W'(fifo_head_reg) == CAP_C - CNT_W'(1)) ? '0
                           : fifo_head_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwce_pkg::BS_IDLE;
            stack_cnt_reg <= '0;
            fifo_cnt_reg  <= '0;
            fifo_head_reg <= '0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stack_cnt_reg <= stack_cnt_next;
            fifo_cnt_reg  <= fifo_cnt_next;
            fifo_head_reg <= fifo_head_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        key_out_reg   <= key_out_next;
        was_empty_reg <= was_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= push_key;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= push_key;
        end
        fifo_rdata_reg <= fifo_mem[fifo_head_reg];
    end

endmodule

FILE: hw/rtl/four_way_container_engine_top.sv
// Heap walk: a heap remove sifts down and an insert sifts up level by level, each
//   step reading the heap memory through its one read port, so the time grows
//   with the heap depth; stack and queue commands do not walk a heap.
// Throughput: one command at a time in the back end; the two-beat queue takes
//   new beats while it has room, even while a command runs or a result waits.
// Reset: counts, queue and control clear at once; stores are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_way_container_engine_top
// Stack, queue, max-heap and min-heap of unsigned keys behind one command port.
// ----------------------------------------------------------------------------
module four_way_container_engine_top #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic [1:0]                       source_sel,
    input  logic [1:0]                       target_sel,
    input  logic [fwce_pkg::KEY_PORT_W-1:0]  key_in,
    // result channel, one beat per pop
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fwce_pkg::KEY_PORT_W-1:0]  key_out,
    output logic                             was_empty
);

    logic           q_full, q_push, q_valid, q_pop;
    fwce_pkg::cmd_t q_wdata, q_head;
    logic [1:0]     q_level;

    // front: classify the beat, mask the key, enqueue
    fwce_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .source_sel (source_sel),
        .target_sel (target_sel),
        .key_in     (key_in),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // decoupling queue: front and back stall independently
    fwce_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head      (q_head),
        .level     (q_level)
    );

    // back: containers, heap sift units and the result register
    fwce_back #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_out   (key_out),
        .was_empty (was_empty)
    );

`ifndef NO_ASSERTIONS
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != 2'd3)
        else $error("command queue overfilled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> q_level != 2'd0)
        else $error("accepted beat lost before the queue");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_empty |-> key_out == '0)
        else $error("empty pop carries a key");
`endif

endmodule
